### design/mfhd_pkg.sv
// ----------------------------------------------------------------------------
// MQTT fixed-header deframer package
// Shared types and constants for the deframer front end, queue and top level.
// ----------------------------------------------------------------------------
package mfhd_pkg;

  // Longest remaining-length field allowed, in bytes.
  localparam int MaxLenBytes = 4;
  // Payload bits carried by one length byte.
  localparam int LenGroupBits = 7;
  localparam int LenWidth = LenGroupBits * MaxLenBytes;

  // Control types that are reserved and reported as errors.
  localparam logic [3:0] TypeReservedLo = 4'h0;
  localparam logic [3:0] TypeReservedHi = 4'hF;

  typedef enum logic [1:0] {
    KindHeader  = 2'd0,
    KindPayload = 2'd1,
    KindError   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ErrNone    = 2'd0,
    ErrBadType = 2'd1,
    ErrLenLong = 2'd2
  } err_e;

  // One result beat as it travels from the front end through the queue.
  typedef struct packed {
    kind_e                item_kind;
    logic [3:0]           control_type;
    logic [3:0]           header_flags;
    logic [LenWidth-1:0]  remaining_length;
    logic [2:0]           length_bytes;
    logic [7:0]           payload_byte;
    logic                 last_of_packet;
    err_e                 error_code;
  } item_t;

endpackage

### design/mfhd_if.sv
// ----------------------------------------------------------------------------
// Deframer channel interfaces
// Valid/ready channels for received bytes and for decoded result beats.
// ----------------------------------------------------------------------------
interface mfhd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       conn_start;

  modport source (output valid, output data_byte, output conn_start, input ready);
  modport sink   (input valid, input data_byte, input conn_start, output ready);
endinterface

interface mfhd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  item_kind;
  logic [3:0]  control_type;
  logic [3:0]  header_flags;
  logic [27:0] remaining_length;
  logic [2:0]  length_bytes;
  logic [7:0]  payload_byte;
  logic        last_of_packet;
  logic [1:0]  error_code;

  modport source (
    output valid, output item_kind, output control_type, output header_flags,
    output remaining_length, output length_bytes, output payload_byte,
    output last_of_packet, output error_code, input ready
  );
  modport sink (
    input valid, input item_kind, input control_type, input header_flags,
    input remaining_length, input length_bytes, input payload_byte,
    input last_of_packet, input error_code, output ready
  );
endinterface

### design/mfhd_front.sv
// ----------------------------------------------------------------------------
// Deframer front end
// Accepts one byte per beat, tracks the packet phase and classifies the byte.
// ----------------------------------------------------------------------------
module mfhd_front import mfhd_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  mfhd_in_if.sink       in_i,
  input  logic          full_i,
  output logic          push_o,
  output item_t         item_o
);

  typedef enum logic [1:0] {
    PhType    = 2'd0,
    PhLen     = 2'd1,
    PhPayload = 2'd2,
    PhDead    = 2'd3
  } phase_e;

  phase_e       phase_q, phase_d, phase_cur;
  logic [3:0]   type_q, type_d;
  logic [3:0]   flags_q, flags_d;
  logic [27:0]  accum_q, accum_d;
  logic [2:0]   cnt_q, cnt_d;
  logic [27:0]  left_q, left_d;
  logic         skip_q, skip_d;
  logic         accept;
  logic [27:0]  group_add;
  logic [LenGroupBits-1:0] group;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign group      = in_i.data_byte[LenGroupBits-1:0];

  // Place the 7-bit group at its position in the length word.
  always_comb begin
    case (cnt_q[1:0])
      2'd0:    group_add = 28'(group);
      2'd1:    group_add = 28'(group) << LenGroupBits;
      2'd2:    group_add = 28'(group) << (2 * LenGroupBits);
      2'd3:    group_add = 28'(group) << (3 * LenGroupBits);
      default: group_add = '0;
    endcase
  end

  always_comb begin
    phase_d   = phase_q;
    type_d    = type_q;
    flags_d   = flags_q;
    accum_d   = accum_q;
    cnt_d     = cnt_q;
    left_d    = left_q;
    skip_d    = skip_q;
    push_o    = 1'b0;
    phase_cur = in_i.conn_start ? PhType : phase_q;

    item_o                  = '0;
    item_o.item_kind        = KindHeader;
    item_o.error_code       = ErrNone;

    if (accept) begin
      case (phase_cur)
        PhType: begin
          type_d  = in_i.data_byte[7:4];
          flags_d = in_i.data_byte[3:0];
          accum_d = '0;
          cnt_d   = '0;
          left_d  = '0;
          skip_d  = (in_i.data_byte[7:4] == TypeReservedLo) ||
                    (in_i.data_byte[7:4] == TypeReservedHi);
          phase_d = PhLen;
        end
        PhLen: begin
          accum_d = accum_q + group_add;
          cnt_d   = cnt_q + 3'd1;
          if (in_i.data_byte[7]) begin
            if (cnt_d >= 3'(MaxLenBytes)) begin
              phase_d           = PhDead;
              push_o            = 1'b1;
              item_o.item_kind  = KindError;
              item_o.error_code = ErrLenLong;
            end
          end else begin
            left_d  = accum_d;
            phase_d = (accum_d == '0) ? PhType : PhPayload;
            push_o  = 1'b1;
            if (skip_q) begin
              item_o.item_kind  = KindError;
              item_o.error_code = ErrBadType;
            end else begin
              item_o.item_kind      = KindHeader;
              item_o.last_of_packet = (accum_d == '0);
            end
          end
        end
        PhPayload: begin
          left_d = left_q - 28'd1;
          if (left_d == '0) begin
            phase_d = PhType;
          end
          if (!skip_q) begin
            push_o                = 1'b1;
            item_o.item_kind      = KindPayload;
            item_o.payload_byte   = in_i.data_byte;
            item_o.last_of_packet = (left_d == '0);
          end
        end
        default: begin
          // Overlong length seen: drop everything until a restart.
        end
      endcase
    end

    item_o.control_type     = type_d;
    item_o.header_flags     = flags_d;
    item_o.remaining_length = accum_d;
    item_o.length_bytes     = cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhType;
      type_q  <= '0;
      flags_q <= '0;
      accum_q <= '0;
      cnt_q   <= '0;
      left_q  <= '0;
      skip_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      type_q  <= type_d;
      flags_q <= flags_d;
      accum_q <= accum_d;
      cnt_q   <= cnt_d;
      left_q  <= left_d;
      skip_q  <= skip_d;
    end
  end

endmodule

### design/mfhd_queue.sv
// ----------------------------------------------------------------------------
// Deframer result queue
// Two-entry queue that decouples the front end from the output channel.
// ----------------------------------------------------------------------------
module mfhd_queue import mfhd_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  item_t         item_i,
  output logic          full_o,
  mfhd_out_if.source    out_o
);

  item_t       mem_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        pop;
  item_t       head;

  assign full_o = (count_q == 2'd2);
  assign head   = mem_q[rd_ptr_q];
  assign pop    = out_o.valid && out_o.ready;

  assign out_o.valid            = (count_q != 2'd0);
  assign out_o.item_kind        = head.item_kind;
  assign out_o.control_type     = head.control_type;
  assign out_o.header_flags     = head.header_flags;
  assign out_o.remaining_length = head.remaining_length;
  assign out_o.length_bytes     = head.length_bytes;
  assign out_o.payload_byte     = head.payload_byte;
  assign out_o.last_of_packet   = head.last_of_packet;
  assign out_o.error_code       = head.error_code;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop;
    count_d  = count_q + 2'(push_i) - 2'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

### design/mqtt_fixed_header_deframer.sv
// ----------------------------------------------------------------------------
// MQTT fixed-header deframer
// Splits one connection's byte stream into header, payload and error beats.
// ----------------------------------------------------------------------------
// Usage:
// The in_i channel carries one received byte per beat, with conn_start set on
// the first byte of a new connection; that byte restarts the parser and is
// taken as the type byte of the first packet. The out_o channel carries the
// decoded beats: one header beat per packet once its length field ends, then
// one beat per payload byte with last_of_packet on the final one. A reserved
// control type yields an error beat instead of the header and its payload is
// dropped; an overlong length field yields an error beat and all bytes are
// dropped until the next restart.
// Throughput is one byte per clock cycle while the result queue is not full.
// A result enters the queue when its byte is accepted and reaches out_o once
// the results ahead of it are taken. Reset empties the two-entry result queue
// and leaves the parser waiting for a type byte. When the receiver stalls, up
// to two results wait in the queue; in_i.ready then drops until one is taken.
// ----------------------------------------------------------------------------
module mqtt_fixed_header_deframer import mfhd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  mfhd_in_if.sink     in_i,
  mfhd_out_if.source  out_o
);

  logic  push;
  logic  q_full;
  item_t item;

  // Front end: the phase machine that classifies each accepted byte and
  // produces at most one result beat for it.
  mfhd_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (q_full),
    .push_o (push),
    .item_o (item)
  );

  // Back end: the queue holds finished beats and drives the output channel,
  // so the front end keeps taking bytes while the receiver is briefly busy.
  mfhd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (item),
    .full_o (q_full),
    .out_o  (out_o)
  );

  // The front end must never write into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push && q_full))
    else $error("result pushed into a full queue");

  // Only error beats carry an error code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ((out_o.item_kind == KindError) == (out_o.error_code != ErrNone)))
    else $error("error code does not match beat kind");

  // Payload byte field is zero on header and error beats.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.item_kind != KindPayload) |-> (out_o.payload_byte == 8'd0))
    else $error("payload byte set on a non-payload beat");

endmodule
